// File: src/sted_pkg.sv
// shared types, codes and defaults of the edge-trigger capture core
package sted_pkg;

	localparam int CHANNELS_DEF    = 4;
	localparam int CAPACITY_DEF    = 4096;
	localparam int SAMPLE_BITS_DEF = 16;

	// fixed field widths of the ports
	localparam int CMD_W       = 3;
	localparam int DATA_W      = 16;
	localparam int INDEX_W     = 12;
	localparam int COUNT_W     = 13;
	localparam int CHAN_W      = 2;
	localparam int INPUTS      = 4;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	// configuration reset values
	localparam logic [2:0]        ACTIVE_RST = 3'd4;
	localparam logic [1:0]        SOURCE_RST = 2'd0;
	localparam logic [DATA_W-1:0] LEVEL_RST  = '0;
	localparam logic [1:0]        MODE_RST   = 2'd0;
	localparam logic              SLOPE_RST  = 1'b0;
	localparam logic              RUN_RST    = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_SAMPLE = 3'd0,
		CMD_FORCE  = 3'd1,
		CMD_CLEAR  = 3'd2,
		CMD_REARM  = 3'd3,
		CMD_READ   = 3'd4
	} cmd_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ACTIVE_CHANNELS = 3'd0,
		REG_TRIGGER_SOURCE  = 3'd1,
		REG_TRIGGER_LEVEL   = 3'd2,
		REG_TRIGGER_MODE    = 3'd3,
		REG_TRIGGER_SLOPE   = 3'd4,
		REG_RUN_ENABLE      = 3'd5
	} cfg_reg_t;

	localparam logic [1:0] MODE_SINGLE = 2'd2;
	localparam logic       SLOPE_FALL  = 1'b1;

	// memory operation handed from front to back
	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef struct packed {
		logic               trigger_seen;
		logic               trigger_fired;
		logic [INDEX_W-1:0] trigger_point;
		logic [COUNT_W-1:0] stored_count;
		logic               capture_frozen;
	} stat_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_data;
		stat_t                    stat;
	} res_t;

endpackage

// File: src/sted_ram.sv
// generic simple dual-port ram with registered read
module sted_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/sted_fifo.sv
// small register fifo used between front, back and the result port
module sted_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           din,
	input  logic                       pop,
	output logic [WIDTH-1:0]           dout,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;

	assign dout  = mem_q[rptr_q];
	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: src/sted_front.sv
// front: configuration, command decode, fill/trigger bookkeeping, memory request build
module sted_front #(
	parameter int CHANNELS    = sted_pkg::CHANNELS_DEF,
	parameter int CAPACITY    = sted_pkg::CAPACITY_DEF,
	parameter int SAMPLE_BITS = sted_pkg::SAMPLE_BITS_DEF,
	localparam int NCH = (CHANNELS < sted_pkg::INPUTS) ? CHANNELS : sted_pkg::INPUTS,
	localparam int AW  = (CAPACITY > 2) ? $clog2(CAPACITY) : 1
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   accept,
	input  logic [sted_pkg::CMD_W-1:0]             command,
	input  logic signed [sted_pkg::DATA_W-1:0]     sample_a,
	input  logic signed [sted_pkg::DATA_W-1:0]     sample_b,
	input  logic signed [sted_pkg::DATA_W-1:0]     sample_c,
	input  logic signed [sted_pkg::DATA_W-1:0]     sample_d,
	input  logic [sted_pkg::CHAN_W-1:0]            read_channel,
	input  logic [sted_pkg::INDEX_W-1:0]           read_index,
	input  logic                                   cfg_write_en,
	input  logic [sted_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [sted_pkg::CFG_DATA_W-1:0]        cfg_data,
	output sted_pkg::op_t                          op,
	output logic [AW-1:0]                          addr,
	output logic [NCH-1:0]                         wmask,
	output logic [NCH-1:0][SAMPLE_BITS-1:0]        wdata,
	output logic [sted_pkg::CHAN_W-1:0]            rchan,
	output sted_pkg::stat_t                        stat
);

	localparam int FW = $clog2(CAPACITY + 1);
	localparam int CW = (SAMPLE_BITS > sted_pkg::DATA_W) ? SAMPLE_BITS : sted_pkg::DATA_W;
	localparam int XW = (FW > sted_pkg::INDEX_W) ? FW : sted_pkg::INDEX_W;
	localparam int SW = ((AW > sted_pkg::INDEX_W) ? AW : sted_pkg::INDEX_W) + 1;

	// configuration
	logic [2:0]                    active_q;
	logic [1:0]                    source_q;
	logic [sted_pkg::DATA_W-1:0]   level_q;
	logic [1:0]                    mode_q;
	logic                          slope_q;
	logic                          run_q;

	// capture bookkeeping
	logic [AW-1:0]                 wh_q;
	logic [FW-1:0]                 fill_q;
	logic [SAMPLE_BITS-1:0]        prev_q;
	logic                          trig_q;
	logic                          single_q;
	logic [AW-1:0]                 last_q;

	logic [AW-1:0]                 wh_nxt;
	logic [FW-1:0]                 fill_nxt;
	logic [SAMPLE_BITS-1:0]        prev_nxt;
	logic                          trig_nxt;
	logic                          single_nxt;
	logic [AW-1:0]                 last_nxt;
	logic                          fired;

	logic signed [sted_pkg::DATA_W-1:0] smp [sted_pkg::INPUTS];
	logic signed [SAMPLE_BITS-1:0] cur_sb;
	logic signed [CW-1:0]          cur_w;
	logic signed [CW-1:0]          prev_w;
	logic signed [CW-1:0]          level_w;
	logic                          src_on;
	logic                          frozen;
	logic                          crossing;
	logic [SW-1:0]                 slot_sum;

	assign smp[0] = sample_a;
	assign smp[1] = sample_b;
	assign smp[2] = sample_c;
	assign smp[3] = sample_d;

	assign frozen  = (mode_q == sted_pkg::MODE_SINGLE) && single_q;
	assign src_on  = (32'(source_q) < 32'(active_q)) && (32'(source_q) < CHANNELS);
	assign cur_sb  = SAMPLE_BITS'(smp[source_q]);
	assign cur_w   = CW'(cur_sb);
	assign prev_w  = CW'($signed(prev_q));
	assign level_w = CW'($signed(level_q));
	assign crossing = (slope_q == sted_pkg::SLOPE_FALL) ?
		(prev_w > level_w && cur_w <= level_w) :
		(prev_w < level_w && cur_w >= level_w);

	// logical index to physical slot once the ring has wrapped
	always_comb begin
		slot_sum = SW'(wh_q) + SW'(read_index);
		if (slot_sum >= SW'(CAPACITY)) begin
			slot_sum = slot_sum - SW'(CAPACITY);
		end
	end

	always_comb begin
		for (int i = 0; i < NCH; i++) begin
			wmask[i] = (32'(active_q) > i);
			wdata[i] = SAMPLE_BITS'(smp[i]);
		end
	end

	always_comb begin
		wh_nxt     = wh_q;
		fill_nxt   = fill_q;
		prev_nxt   = prev_q;
		trig_nxt   = trig_q;
		single_nxt = single_q;
		last_nxt   = last_q;
		fired      = 1'b0;
		op         = sted_pkg::OP_NONE;
		addr       = wh_q;
		rchan      = read_channel;
		case (command)
			sted_pkg::CMD_SAMPLE: begin
				if (run_q && !frozen) begin
					op       = sted_pkg::OP_WRITE;
					wh_nxt   = (wh_q == AW'(CAPACITY - 1)) ? '0 : wh_q + 1'b1;
					fill_nxt = (fill_q < FW'(CAPACITY)) ? fill_q + 1'b1 : fill_q;
					if (src_on && fill_nxt > FW'(1)) begin
						prev_nxt = cur_sb;
						if (crossing) begin
							fired    = 1'b1;
							trig_nxt = 1'b1;
							last_nxt = AW'(fill_nxt - 1'b1);
							if (mode_q == sted_pkg::MODE_SINGLE) begin
								single_nxt = 1'b1;
							end
						end
					end
				end
			end
			sted_pkg::CMD_FORCE: begin
				trig_nxt   = 1'b1;
				last_nxt   = (fill_q != '0) ? AW'(fill_q - 1'b1) : '0;
				single_nxt = 1'b0;
			end
			sted_pkg::CMD_CLEAR: begin
				op         = sted_pkg::OP_CLEAR;
				wh_nxt     = '0;
				fill_nxt   = '0;
				prev_nxt   = '0;
				trig_nxt   = 1'b0;
				single_nxt = 1'b0;
				last_nxt   = '0;
			end
			sted_pkg::CMD_REARM: begin
				single_nxt = 1'b0;
			end
			sted_pkg::CMD_READ: begin
				if (32'(read_channel) < CHANNELS && XW'(read_index) < XW'(fill_q)) begin
					op   = sted_pkg::OP_READ;
					addr = (fill_q < FW'(CAPACITY)) ? AW'(read_index) : AW'(slot_sum);
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		stat.trigger_seen   = trig_nxt;
		stat.trigger_fired  = fired;
		stat.trigger_point  = sted_pkg::INDEX_W'(last_nxt);
		stat.stored_count   = sted_pkg::COUNT_W'(fill_nxt);
		stat.capture_frozen = (mode_q == sted_pkg::MODE_SINGLE) && single_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= sted_pkg::ACTIVE_RST;
			source_q <= sted_pkg::SOURCE_RST;
			level_q  <= sted_pkg::LEVEL_RST;
			mode_q   <= sted_pkg::MODE_RST;
			slope_q  <= sted_pkg::SLOPE_RST;
			run_q    <= sted_pkg::RUN_RST;
			wh_q     <= '0;
			fill_q   <= '0;
			prev_q   <= '0;
			trig_q   <= 1'b0;
			single_q <= 1'b0;
			last_q   <= '0;
		end else begin
			if (accept) begin
				wh_q     <= wh_nxt;
				fill_q   <= fill_nxt;
				prev_q   <= prev_nxt;
				trig_q   <= trig_nxt;
				single_q <= single_nxt;
				last_q   <= last_nxt;
			end
			if (cfg_write_en) begin
				case (cfg_index)
					sted_pkg::REG_ACTIVE_CHANNELS: active_q <= cfg_data[2:0];
					sted_pkg::REG_TRIGGER_SOURCE:  source_q <= cfg_data[1:0];
					sted_pkg::REG_TRIGGER_LEVEL:   level_q  <= cfg_data;
					sted_pkg::REG_TRIGGER_MODE: begin
						mode_q   <= cfg_data[1:0];
						single_q <= 1'b0;
					end
					sted_pkg::REG_TRIGGER_SLOPE:   slope_q  <= cfg_data[0];
					sted_pkg::REG_RUN_ENABLE: begin
						run_q <= cfg_data[0];
						if (cfg_data[0]) begin
							single_q <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// File: src/sted_back.sv
// back: sample store access, clearing sweep and result queue
module sted_back #(
	parameter int CHANNELS    = sted_pkg::CHANNELS_DEF,
	parameter int CAPACITY    = sted_pkg::CAPACITY_DEF,
	parameter int SAMPLE_BITS = sted_pkg::SAMPLE_BITS_DEF,
	localparam int NCH = (CHANNELS < sted_pkg::INPUTS) ? CHANNELS : sted_pkg::INPUTS,
	localparam int AW  = (CAPACITY > 2) ? $clog2(CAPACITY) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_take,
	input  sted_pkg::op_t                   op,
	input  logic [AW-1:0]                   addr,
	input  logic [NCH-1:0]                  wmask,
	input  logic [NCH-1:0][SAMPLE_BITS-1:0] wdata,
	input  logic [sted_pkg::CHAN_W-1:0]     rchan,
	input  sted_pkg::stat_t                 stat,
	output logic                            sweeping,
	input  logic                            pop,
	output logic                            empty,
	output sted_pkg::res_t                  res
);

	localparam int OCW = $clog2(sted_pkg::OUT_DEPTH + 1);
	localparam int RW  = $bits(sted_pkg::res_t);

	logic                        sweep_q;
	logic [AW-1:0]               sweep_cnt_q;

	logic                        v_s1;
	logic                        rd_s1;
	logic [sted_pkg::CHAN_W-1:0] rchan_s1;
	sted_pkg::stat_t             stat_s1;

	logic [NCH-1:0]              ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [NCH-1:0][SAMPLE_BITS-1:0] ram_wdata;
	logic [SAMPLE_BITS-1:0]      ram_rdata [NCH];

	logic                        out_pop;
	logic [OCW-1:0]              out_count;
	logic [RW-1:0]               out_dout;
	logic signed [SAMPLE_BITS-1:0] sel_data;
	sted_pkg::res_t              res_s1;

	assign sweeping = sweep_q;
	assign out_pop  = pop && !empty;

	// room check counts the request already in the read stage
	assign req_take = req_valid && !sweep_q &&
		((OCW + 1)'(out_count) + (OCW + 1)'(v_s1) <
		 (OCW + 1)'(sted_pkg::OUT_DEPTH) + (OCW + 1)'(out_pop));

	always_comb begin
		for (int i = 0; i < NCH; i++) begin
			ram_we[i]    = sweep_q || (req_take && op == sted_pkg::OP_WRITE && wmask[i]);
			ram_wdata[i] = sweep_q ? '0 : wdata[i];
		end
		ram_waddr = sweep_q ? sweep_cnt_q : addr;
	end

	for (genvar g = 0; g < NCH; g++) begin : g_ram
		sted_ram #(
			.WIDTH (SAMPLE_BITS),
			.DEPTH (CAPACITY)
		) u_ram (
			.clk   (clk),
			.we    (ram_we[g]),
			.waddr (ram_waddr),
			.wdata (ram_wdata[g]),
			.raddr (addr),
			.rdata (ram_rdata[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= 1'b1;
			sweep_cnt_q <= '0;
			v_s1        <= 1'b0;
		end else begin
			v_s1 <= req_take;
			if (sweep_q) begin
				sweep_cnt_q <= sweep_cnt_q + 1'b1;
				if (sweep_cnt_q == AW'(CAPACITY - 1)) begin
					sweep_q     <= 1'b0;
					sweep_cnt_q <= '0;
				end
			end else if (req_take && op == sted_pkg::OP_CLEAR) begin
				sweep_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			rd_s1    <= (op == sted_pkg::OP_READ);
			rchan_s1 <= rchan;
			stat_s1  <= stat;
		end
	end

	always_comb begin
		sel_data = '0;
		for (int i = 0; i < NCH; i++) begin
			if (32'(rchan_s1) == i) begin
				sel_data = ram_rdata[i];
			end
		end
		res_s1.read_data = rd_s1 ? sted_pkg::DATA_W'(sel_data) : '0;
		res_s1.stat      = stat_s1;
	end

	sted_fifo #(
		.WIDTH (RW),
		.DEPTH (sted_pkg::OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (v_s1),
		.din    (res_s1),
		.pop    (out_pop),
		.dout   (out_dout),
		.full   (),
		.empty  (empty),
		.count  (out_count)
	);

	assign res = sted_pkg::res_t'(out_dout);

endmodule

// File: src/scope_edge_trigger_capture_core.sv
// Edge-trigger capture core: front decode, request queue, store back end, result queue.
// Results: each accepted command passes the request queue, the read stage and the result queue before it is visible.
// Throughput: one command per cycle while full is low; a clear command makes the back end
// sweep every store address to zero, during which full is high.
// Reset: registers return to defaults and the store is swept to zero after reset
// with full held high; configuration writes are taken throughout.
module scope_edge_trigger_capture_core #(
	parameter int CHANNELS    = sted_pkg::CHANNELS_DEF,
	parameter int CAPACITY    = sted_pkg::CAPACITY_DEF,
	parameter int SAMPLE_BITS = sted_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [sted_pkg::CMD_W-1:0]          command,
	input  logic signed [sted_pkg::DATA_W-1:0]  sample_a,
	input  logic signed [sted_pkg::DATA_W-1:0]  sample_b,
	input  logic signed [sted_pkg::DATA_W-1:0]  sample_c,
	input  logic signed [sted_pkg::DATA_W-1:0]  sample_d,
	input  logic [sted_pkg::CHAN_W-1:0]         read_channel,
	input  logic [sted_pkg::INDEX_W-1:0]        read_index,
	input  logic                                cfg_write_en,
	input  logic [sted_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [sted_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [sted_pkg::DATA_W-1:0]  read_data,
	output logic                                trigger_seen,
	output logic                                trigger_fired,
	output logic [sted_pkg::INDEX_W-1:0]        trigger_point,
	output logic [sted_pkg::COUNT_W-1:0]        stored_count,
	output logic                                capture_frozen
);

	localparam int NCH = (CHANNELS < sted_pkg::INPUTS) ? CHANNELS : sted_pkg::INPUTS;
	localparam int AW  = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
	localparam int MW  = 2 + AW + NCH + NCH * SAMPLE_BITS + sted_pkg::CHAN_W +
		$bits(sted_pkg::stat_t);

	logic                            accept;
	logic                            mid_full;
	logic                            mid_empty;
	logic                            mid_take;
	logic [MW-1:0]                   mid_din;
	logic [MW-1:0]                   mid_dout;
	logic                            sweeping;

	sted_pkg::op_t                   f_op;
	logic [AW-1:0]                   f_addr;
	logic [NCH-1:0]                  f_wmask;
	logic [NCH-1:0][SAMPLE_BITS-1:0] f_wdata;
	logic [sted_pkg::CHAN_W-1:0]     f_rchan;
	sted_pkg::stat_t                 f_stat;

	logic [1:0]                      b_op_raw;
	logic [AW-1:0]                   b_addr;
	logic [NCH-1:0]                  b_wmask;
	logic [NCH-1:0][SAMPLE_BITS-1:0] b_wdata;
	logic [sted_pkg::CHAN_W-1:0]     b_rchan;
	sted_pkg::stat_t                 b_stat;
	sted_pkg::res_t                  res;

	assign full   = mid_full || sweeping;
	assign accept = push && !full;

	sted_front #(
		.CHANNELS    (CHANNELS),
		.CAPACITY    (CAPACITY),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.command      (command),
		.sample_a     (sample_a),
		.sample_b     (sample_b),
		.sample_c     (sample_c),
		.sample_d     (sample_d),
		.read_channel (read_channel),
		.read_index   (read_index),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.op           (f_op),
		.addr         (f_addr),
		.wmask        (f_wmask),
		.wdata        (f_wdata),
		.rchan        (f_rchan),
		.stat         (f_stat)
	);

	assign mid_din = {f_op, f_addr, f_wmask, f_wdata, f_rchan, f_stat};

	sted_fifo #(
		.WIDTH (MW),
		.DEPTH (sted_pkg::MID_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.din    (mid_din),
		.pop    (mid_take),
		.dout   (mid_dout),
		.full   (mid_full),
		.empty  (mid_empty),
		.count  ()
	);

	assign {b_op_raw, b_addr, b_wmask, b_wdata, b_rchan, b_stat} = mid_dout;

	sted_back #(
		.CHANNELS    (CHANNELS),
		.CAPACITY    (CAPACITY),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (!mid_empty),
		.req_take  (mid_take),
		.op        (sted_pkg::op_t'(b_op_raw)),
		.addr      (b_addr),
		.wmask     (b_wmask),
		.wdata     (b_wdata),
		.rchan     (b_rchan),
		.stat      (b_stat),
		.sweeping  (sweeping),
		.pop       (pop),
		.empty     (empty),
		.res       (res)
	);

	assign read_data      = res.read_data;
	assign trigger_seen   = res.stat.trigger_seen;
	assign trigger_fired  = res.stat.trigger_fired;
	assign trigger_point  = res.stat.trigger_point;
	assign stored_count   = res.stat.stored_count;
	assign capture_frozen = res.stat.capture_frozen;

endmodule

// File: tb/tb.sv
// self-checking testbench for the edge-trigger capture core
module tb;
	import sted_pkg::*;

	localparam int CYCLE_LIMIT = 800000;
	localparam logic [1:0] MODE_AUTO   = 2'd0;
	localparam logic [1:0] MODE_NORMAL = 2'd1;
	localparam logic [1:0] MODE_SPARE  = 2'd3;
	localparam logic       SLOPE_RISE  = 1'b0;
	localparam logic [2:0] CMD_SPARE_LO = 3'd5;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [CMD_W-1:0]          command;
		logic [3:0][DATA_W-1:0]    smp;
		logic [CHAN_W-1:0]         rd_chan;
		logic [INDEX_W-1:0]        rd_idx;
	} scope_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [CMD_W-1:0] command = '0;
	logic signed [DATA_W-1:0] sample_a = '0;
	logic signed [DATA_W-1:0] sample_b = '0;
	logic signed [DATA_W-1:0] sample_c = '0;
	logic signed [DATA_W-1:0] sample_d = '0;
	logic [CHAN_W-1:0] read_channel = '0;
	logic [INDEX_W-1:0] read_index = '0;
	logic cfg_write_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic empty;
	logic pop = 1'b0;
	logic signed [DATA_W-1:0] read_data;
	logic trigger_seen;
	logic trigger_fired;
	logic [INDEX_W-1:0] trigger_point;
	logic [COUNT_W-1:0] stored_count;
	logic capture_frozen;

	scope_edge_trigger_capture_core DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .command(command),
		.sample_a(sample_a), .sample_b(sample_b), .sample_c(sample_c), .sample_d(sample_d),
		.read_channel(read_channel), .read_index(read_index),
		.cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.empty(empty), .pop(pop), .read_data(read_data), .trigger_seen(trigger_seen),
		.trigger_fired(trigger_fired), .trigger_point(trigger_point),
		.stored_count(stored_count), .capture_frozen(capture_frozen)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// capture state as the block should hold it
	logic [DATA_W-1:0] scope_mem [CHANNELS_DEF][CAPACITY_DEF];
	logic [INDEX_W-1:0] wr_head;
	logic [COUNT_W-1:0] fill_level;
	logic signed [DATA_W-1:0] prev_trig;
	logic trig_flag;
	logic one_shot_done;
	logic [INDEX_W-1:0] trig_index;
	logic [2:0] cfg_active;
	logic [1:0] cfg_source;
	logic signed [DATA_W-1:0] cfg_level;
	logic [1:0] cfg_mode;
	logic cfg_slope;
	logic cfg_run;

	scope_req_t cmd_backlog [$];
	res_t pending_results [$];
	scope_req_t drive_req;
	res_t want;

	int error_count = 0;
	int reqs_sent = 0;
	int results_checked = 0;
	int crossings_seen = 0;
	int wrapped_reads = 0;
	int clears_sent = 0;
	int settings_applied = 0;
	int gen_fill = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_style = 0;
	int stall_left = 0;
	logic [1:0] pop_phase = '0;

	task automatic report_mismatch(string what, logic [15:0] exp_v, logic [15:0] got_v);
		if (error_count < 50)
			$display("tb: mismatch on %s at result %0d: expected %0h, got %0h",
				what, results_checked, exp_v, got_v);
		error_count++;
	endtask

	function automatic void wipe_store();
		for (int ch = 0; ch < CHANNELS_DEF; ch++)
			for (int i = 0; i < CAPACITY_DEF; i++)
				scope_mem[ch][i] = '0;
		wr_head = '0;
		fill_level = '0;
		prev_trig = '0;
		trig_flag = 1'b0;
		one_shot_done = 1'b0;
		trig_index = '0;
	endfunction

	function automatic logic frozen_now();
		return cfg_mode == MODE_SINGLE && one_shot_done;
	endfunction

	function automatic res_t capture_step(scope_req_t r);
		res_t res;
		logic [2:0] lanes;
		logic [INDEX_W-1:0] slot;
		logic signed [DATA_W-1:0] cur;
		logic crossing;
		res = '0;
		crossing = 1'b0;
		lanes = (cfg_active > 3'(CHANNELS_DEF)) ? 3'(CHANNELS_DEF) : cfg_active;
		case (r.command)
		CMD_SAMPLE: begin
			if (cfg_run && !frozen_now()) begin
				for (int ch = 0; ch < CHANNELS_DEF; ch++)
					if (ch < lanes)
						scope_mem[ch][wr_head] = r.smp[ch];
				wr_head = wr_head + 1'b1;
				if (fill_level < CAPACITY_DEF)
					fill_level = fill_level + 1'b1;
				if (cfg_source < lanes && fill_level > 1) begin
					cur = $signed(r.smp[cfg_source]);
					if (cfg_slope == SLOPE_RISE)
						crossing = prev_trig < cfg_level && cur >= cfg_level;
					else
						crossing = prev_trig > cfg_level && cur <= cfg_level;
					if (crossing) begin
						trig_flag = 1'b1;
						trig_index = 12'(fill_level - 1'b1);
						if (cfg_mode == MODE_SINGLE)
							one_shot_done = 1'b1;
						crossings_seen++;
					end
					prev_trig = cur;
				end
			end
		end
		CMD_FORCE: begin
			trig_flag = 1'b1;
			trig_index = (fill_level != 0) ? 12'(fill_level - 1'b1) : '0;
			one_shot_done = 1'b0;
		end
		CMD_CLEAR: wipe_store();
		CMD_REARM: one_shot_done = 1'b0;
		CMD_READ: begin
			if (r.rd_idx < fill_level) begin
				// once full, the oldest sample sits at the write head
				if (fill_level < CAPACITY_DEF) begin
					slot = r.rd_idx;
				end else begin
					slot = wr_head + r.rd_idx;
					wrapped_reads++;
				end
				res.read_data = scope_mem[r.rd_chan][slot];
			end
		end
		default: ;
		endcase
		res.stat.trigger_seen = trig_flag;
		res.stat.trigger_fired = crossing;
		res.stat.trigger_point = trig_index;
		res.stat.stored_count = fill_level;
		res.stat.capture_frozen = frozen_now();
		return res;
	endfunction

	// sender: bursts of requests with random gaps
	always @(posedge clk) begin
		if (push && !full) begin
			pending_results.push_back(capture_step(drive_req));
			reqs_sent++;
		end
		if (!arst_n) begin
			push <= 1'b0;
		end else if (push && full) begin
			push <= 1'b1;
		end else if (gap_left != 0) begin
			gap_left--;
			push <= 1'b0;
		end else if (cmd_backlog.size() != 0) begin
			drive_req = cmd_backlog.pop_front();
			command <= drive_req.command;
			sample_a <= drive_req.smp[0];
			sample_b <= drive_req.smp[1];
			sample_c <= drive_req.smp[2];
			sample_d <= drive_req.smp[3];
			read_channel <= drive_req.rd_chan;
			read_index <= drive_req.rd_idx;
			push <= 1'b1;
			if (burst_left != 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(0, 40);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
			end
		end else begin
			push <= 1'b0;
		end
	end

	// receiver: compare each popped result, stall on a changing pattern
	always @(posedge clk) begin
		if (pop && !empty) begin
			results_checked++;
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request pending", '0, read_data);
			end else begin
				want = pending_results.pop_front();
				if (read_data !== want.read_data)
					report_mismatch("read_data", want.read_data, read_data);
				if (trigger_seen !== want.stat.trigger_seen)
					report_mismatch("trigger_seen", want.stat.trigger_seen, trigger_seen);
				if (trigger_fired !== want.stat.trigger_fired)
					report_mismatch("trigger_fired", want.stat.trigger_fired, trigger_fired);
				if (trigger_point !== want.stat.trigger_point)
					report_mismatch("trigger_point", want.stat.trigger_point, trigger_point);
				if (stored_count !== want.stat.stored_count)
					report_mismatch("stored_count", want.stat.stored_count, stored_count);
				if (capture_frozen !== want.stat.capture_frozen)
					report_mismatch("capture_frozen", want.stat.capture_frozen,
						capture_frozen);
			end
		end
		if (stall_left == 0) begin
			stall_style = $urandom_range(0, 3);
			stall_left = (stall_style == 3) ? $urandom_range(1, 25) : $urandom_range(20, 150);
		end else begin
			stall_left--;
		end
		pop_phase <= pop_phase + 1'b1;
		case (stall_style)
		0: pop <= 1'b1;
		1: pop <= ($urandom_range(0, 99) >= 40);
		2: pop <= (pop_phase == 2'd0);
		default: pop <= 1'b0;
		endcase
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: done, errors");
		$finish;
	end

	task automatic apply_setting(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		case (idx)
		REG_ACTIVE_CHANNELS: cfg_active = val[2:0];
		REG_TRIGGER_SOURCE:  cfg_source = val[1:0];
		REG_TRIGGER_LEVEL:   cfg_level = val;
		REG_TRIGGER_MODE: begin
			cfg_mode = val[1:0];
			one_shot_done = 1'b0;
		end
		REG_TRIGGER_SLOPE:   cfg_slope = val[0];
		REG_RUN_ENABLE: begin
			cfg_run = val[0];
			if (val[0])
				one_shot_done = 1'b0;
		end
		default: ;
		endcase
		settings_applied++;
	endtask

	// hold off until every outstanding request has returned
	task automatic drain();
		do
			@(negedge clk);
		while (cmd_backlog.size() != 0 || push || pending_results.size() != 0);
	endtask

	task automatic queue_cmd(logic [2:0] c, logic [15:0] a, b, cc, d,
			logic [1:0] ch, logic [11:0] idx);
		scope_req_t r;
		r.command = c;
		r.smp = {d, cc, b, a};
		r.rd_chan = ch;
		r.rd_idx = idx;
		cmd_backlog.push_back(r);
		if (c == CMD_SAMPLE && gen_fill < CAPACITY_DEF)
			gen_fill++;
		if (c == CMD_CLEAR) begin
			gen_fill = 0;
			clears_sent++;
		end
	endtask

	function automatic logic [15:0] near_level(int spread);
		int v;
		v = int'(cfg_level) + int'($urandom_range(0, 2 * spread)) - spread;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return 16'(v);
	endfunction

	task automatic queue_sample(bit hover);
		if (hover)
			queue_cmd(CMD_SAMPLE, near_level(300), near_level(300), near_level(300),
				near_level(300), 2'($urandom), 12'($urandom));
		else
			queue_cmd(CMD_SAMPLE, 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 2'($urandom), 12'($urandom));
	endtask

	task automatic queue_read();
		logic [11:0] idx;
		if ($urandom_range(0, 9) < 7)
			idx = 12'($urandom_range(0, gen_fill < 4095 ? gen_fill + 1 : 4095));
		else
			idx = 12'($urandom);
		queue_cmd(CMD_READ, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			2'($urandom), idx);
	endtask

	task automatic queue_other(logic [2:0] c);
		queue_cmd(c, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			2'($urandom), 12'($urandom));
	endtask

	task automatic queue_random_cmd();
		int roll;
		roll = $urandom_range(0, 199);
		if (roll < 110)
			queue_sample($urandom_range(0, 3) != 0);
		else if (roll < 160)
			queue_read();
		else if (roll < 170)
			queue_other(CMD_FORCE);
		else if (roll < 180)
			queue_other(CMD_REARM);
		else if (roll < 184)
			queue_other(CMD_CLEAR);
		else if (roll < 192)
			queue_other(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)));
		else
			queue_sample(1'b0);
	endtask

	task automatic pick_settings();
		logic [15:0] level;
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			level = 16'h8000;
		else if (roll == 1)
			level = 16'h7FFF;
		else
			level = 16'(int'($urandom_range(0, 4000)) - 2000);
		apply_setting(REG_ACTIVE_CHANNELS,
			($urandom_range(0, 2) != 0) ? 16'd4 : 16'($urandom_range(0, 7)));
		apply_setting(REG_TRIGGER_SOURCE, 16'($urandom_range(0, 3)));
		apply_setting(REG_TRIGGER_LEVEL, level);
		apply_setting(REG_TRIGGER_SLOPE, 16'($urandom_range(0, 1)));
		apply_setting(REG_TRIGGER_MODE,
			($urandom_range(0, 2) == 0) ? 16'(MODE_SINGLE) : 16'($urandom_range(0, 3)));
		apply_setting(REG_RUN_ENABLE, ($urandom_range(0, 9) != 0) ? 16'd1 : 16'd0);
	endtask

	// fill past capacity so the store wraps and the count saturates
	task automatic run_long_fill();
		int n;
		apply_setting(REG_ACTIVE_CHANNELS, 16'd4);
		apply_setting(REG_TRIGGER_SOURCE, 16'd1);
		apply_setting(REG_TRIGGER_LEVEL, 16'd0);
		apply_setting(REG_TRIGGER_SLOPE, 16'($urandom_range(0, 1)));
		apply_setting(REG_TRIGGER_MODE, 16'(MODE_NORMAL));
		apply_setting(REG_RUN_ENABLE, 16'd1);
		queue_other(CMD_CLEAR);
		n = CAPACITY_DEF + $urandom_range(1, 300);
		for (int i = 0; i < n; i++) begin
			queue_sample($urandom_range(0, 1) != 0);
			if (i % 256 == 255)
				queue_read();
		end
		queue_cmd(CMD_READ, '0, '0, '0, '0, 2'd0, 12'd0);
		queue_cmd(CMD_READ, '0, '0, '0, '0, 2'd3, 12'd4095);
		queue_cmd(CMD_READ, '0, '0, '0, '0, 2'd1, 12'd4094);
		for (int i = 0; i < 20; i++)
			queue_read();
		queue_other(CMD_FORCE);
		drain();
	endtask

	initial begin
		cfg_active = ACTIVE_RST;
		cfg_source = SOURCE_RST;
		cfg_level = LEVEL_RST;
		cfg_mode = MODE_RST;
		cfg_slope = SLOPE_RST;
		cfg_run = RUN_RST;
		wipe_store();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// defaults: empty read, sample extremes, rising crossing, other commands
		queue_cmd(CMD_READ, '0, '0, '0, '0, 2'd0, 12'd0);
		queue_cmd(CMD_SAMPLE, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 2'd3, 12'hFFF);
		queue_cmd(CMD_SAMPLE, 16'hFFFB, 16'd1, 16'd2, 16'd3, 2'd0, 12'd0);
		queue_cmd(CMD_SAMPLE, 16'h0000, 16'h8000, 16'h7FFF, 16'h5A5A, 2'd0, 12'd0);
		queue_cmd(CMD_READ, '0, '0, '0, '0, 2'd1, 12'd0);
		queue_cmd(CMD_READ, '0, '0, '0, '0, 2'd3, 12'hFFF);
		queue_cmd(CMD_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd0, 12'd2);
		queue_other(CMD_FORCE);
		queue_other(CMD_SPARE_LO);
		queue_other(CMD_SPARE_HI);
		queue_other(CMD_REARM);
		queue_other(CMD_CLEAR);
		queue_cmd(CMD_FORCE, '0, '0, '0, '0, 2'd0, 12'd0);
		queue_cmd(CMD_READ, '0, '0, '0, '0, 2'd2, 12'd0);
		drain();

		// single shot on a falling crossing of the lowest level
		apply_setting(REG_TRIGGER_SOURCE, 16'd3);
		apply_setting(REG_TRIGGER_LEVEL, 16'h8000);
		apply_setting(REG_TRIGGER_SLOPE, 16'(SLOPE_FALL));
		apply_setting(REG_TRIGGER_MODE, 16'(MODE_SINGLE));
		queue_cmd(CMD_SAMPLE, 16'd1, 16'd2, 16'd3, 16'd0, 2'd0, 12'd0);
		queue_cmd(CMD_SAMPLE, 16'd1, 16'd2, 16'd3, 16'd100, 2'd0, 12'd0);
		queue_cmd(CMD_SAMPLE, 16'd1, 16'd2, 16'd3, 16'h8000, 2'd0, 12'd0);
		queue_cmd(CMD_SAMPLE, 16'd9, 16'd9, 16'd9, 16'd9, 2'd0, 12'd0);
		queue_other(CMD_REARM);
		queue_cmd(CMD_SAMPLE, 16'd7, 16'd7, 16'd7, 16'd7, 2'd0, 12'd0);
		drain();

		// stopped, too many channels, undefined mode, highest level
		apply_setting(REG_RUN_ENABLE, 16'd0);
		apply_setting(REG_ACTIVE_CHANNELS, 16'd7);
		apply_setting(REG_TRIGGER_MODE, 16'(MODE_SPARE));
		apply_setting(REG_TRIGGER_LEVEL, 16'h7FFF);
		apply_setting(REG_TRIGGER_SLOPE, 16'(SLOPE_RISE));
		queue_sample(1'b0);
		drain();

		// trigger source beyond the active channels, then no channels at all
		apply_setting(REG_RUN_ENABLE, 16'd1);
		apply_setting(REG_ACTIVE_CHANNELS, 16'd2);
		queue_cmd(CMD_SAMPLE, 16'd11, 16'd22, 16'd33, 16'h7FFF, 2'd0, 12'd0);
		queue_cmd(CMD_READ, '0, '0, '0, '0, 2'd3, 12'd0);
		drain();
		apply_setting(REG_ACTIVE_CHANNELS, 16'd0);
		apply_setting(REG_TRIGGER_MODE, 16'(MODE_AUTO));
		queue_sample(1'b0);
		queue_cmd(CMD_READ, '0, '0, '0, '0, 2'd0, 12'(gen_fill - 1));
		drain();

		for (int p = 0; p < 10; p++) begin
			pick_settings();
			for (int i = 0; i < 55; i++)
				queue_random_cmd();
			drain();
			if (p == 4)
				run_long_fill();
		end

		repeat (10) @(posedge clk);
		while (pending_results.size() != 0) begin
			want = pending_results.pop_front();
			report_mismatch("result never returned", want.read_data, '0);
		end
		$display("tb: %0d commands accepted, %0d results compared, %0d trigger crossings, %0d clears",
			reqs_sent, results_checked, crossings_seen, clears_sent);
		$display("tb: %0d register writes, %0d reads from a wrapped full store",
			settings_applied, wrapped_reads);
		if (error_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

// File: filelist.f
src/sted_pkg.sv
src/sted_ram.sv
src/sted_fifo.sv
src/sted_front.sv
src/sted_back.sv
src/scope_edge_trigger_capture_core.sv
tb/tb.sv
